>>> rtl/gcl_pkg.sv
// Shared widths, result types and status types for the GCD/LCM unit.
`default_nettype none

package gcl_pkg;

    // Number of low operand bits that take part in the computation.
    localparam int OPERAND_WIDTH = 16;

    // Fixed widths of the stream fields.
    localparam int FIELD_W = 16;
    localparam int LCM_W   = 32;

    // Effective operand width: the input fields carry 16 bits at most.
    localparam int OP_W  = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;
    localparam int LW    = 2 * OP_W;
    localparam int CNT_W = $clog2(OP_W + 1);

    // Stream payload widths.
    localparam int IN_DATA_W  = 2 * FIELD_W;
    localparam int OUT_DATA_W = FIELD_W + LCM_W;

    typedef struct packed {
        logic               err;
        logic [LCM_W-1:0]   lcm;
        logic [FIELD_W-1:0] gcd;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

endpackage

`default_nettype wire

>>> rtl/gcl_addsub.sv
// Shared adder/subtractor used by the reduction, division and multiply phases of the GCD/LCM sequencer.
`default_nettype none

module gcl_addsub
    import gcl_pkg::*;
(
    input  wire logic [LW-1:0] i_x,
    input  wire logic [LW-1:0] i_y,
    input  wire logic          i_sub,
    output logic      [LW-1:0] o_sum,
    output logic               o_borrow
);

    logic [LW:0] w_full;

    // Subtraction is x + ~y + 1; the carry out is low exactly when x < y.
    assign w_full   = {1'b0, i_x} + {1'b0, (i_y ^ {LW{i_sub}})} + {{LW{1'b0}}, i_sub};
    assign o_sum    = w_full[LW-1:0];
    assign o_borrow = i_sub & ~w_full[LW];

endmodule

`default_nettype wire

>>> rtl/gcl_seq.sv
// Sequencer for binary GCD, restoring division and shift-add multiply.
`default_nettype none

module gcl_seq
    import gcl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [FIELD_W-1:0] i_operand_a,
    input  wire logic [FIELD_W-1:0] i_operand_b,
    input  wire logic               i_take,
    output t_seq_stat               o_stat,
    output t_result                 o_result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALIGN  = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [OP_W-1:0]  r_opa,   n_opa;
    logic [OP_W-1:0]  r_opb,   n_opb;
    logic [OP_W-1:0]  r_x,     n_x;
    logic [OP_W-1:0]  r_y,     n_y;
    logic [CNT_W-1:0] r_k,     n_k;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [OP_W-1:0]  r_gcd,   n_gcd;
    logic [OP_W-1:0]  r_rem,   n_rem;
    logic [LW-1:0]    r_acc,   n_acc;
    logic [LW-1:0]    r_mcand, n_mcand;
    logic             r_err,   n_err;

    logic [OP_W-1:0]  w_a;
    logic [OP_W-1:0]  w_b;
    logic [OP_W:0]    w_trial;
    logic [LW-1:0]    w_alu_x;
    logic [LW-1:0]    w_alu_y;
    logic             w_alu_sub;
    logic [LW-1:0]    w_alu_sum;
    logic             w_alu_borrow;

    assign w_a     = i_operand_a[OP_W-1:0];
    assign w_b     = i_operand_b[OP_W-1:0];
    assign w_trial = {r_rem, r_x[OP_W-1]};

    // Operand selection for the shared unit.
    always_comb begin
        case (r_state)
            S_DIV: begin
                w_alu_x   = LW'(w_trial);
                w_alu_y   = LW'(r_gcd);
                w_alu_sub = 1'b1;
            end
            S_MUL: begin
                w_alu_x   = r_acc;
                w_alu_y   = r_mcand;
                w_alu_sub = 1'b0;
            end
            default: begin
                w_alu_x   = LW'(r_y);
                w_alu_y   = LW'(r_x);
                w_alu_sub = 1'b1;
            end
        endcase
    end

    gcl_addsub u_addsub (
        .i_x      (w_alu_x),
        .i_y      (w_alu_y),
        .i_sub    (w_alu_sub),
        .o_sum    (w_alu_sum),
        .o_borrow (w_alu_borrow)
    );

    always_comb begin
        n_state = r_state;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_gcd   = r_gcd;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_err   = r_err;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_opa = w_a;
                    n_opb = w_b;
                    n_x   = w_a;
                    n_y   = w_b;
                    n_k   = '0;
                    if (w_a == '0 || w_b == '0) begin
                        n_err   = 1'b1;
                        n_gcd   = '0;
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_ALIGN;
                    end
                end
            end
            S_ALIGN: begin
                // Strip the common factors of two; they are restored at the end.
                if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + CNT_W'(1);
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (w_alu_borrow) begin
                    // Keep the smaller odd value in x.
                    n_x = r_y;
                    n_y = r_x;
                end else if (w_alu_sum[OP_W-1:0] == '0) begin
                    n_gcd   = r_x << r_k;
                    n_x     = r_opa;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_y = w_alu_sum[OP_W-1:0];
                end
            end
            S_DIV: begin
                // One quotient bit per cycle; x shifts the dividend out and the quotient in.
                if (w_alu_borrow) begin
                    n_rem = w_trial[OP_W-1:0];
                    n_x   = {r_x[OP_W-2:0], 1'b0};
                end else begin
                    n_rem = w_alu_sum[OP_W-1:0];
                    n_x   = {r_x[OP_W-2:0], 1'b1};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(OP_W - 1)) begin
                    n_acc   = '0;
                    n_mcand = LW'(r_opb);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_x == '0) begin
                    n_state = S_DONE;
                end else begin
                    if (r_x[0]) begin
                        n_acc = w_alu_sum;
                    end
                    n_x     = r_x >> 1;
                    n_mcand = r_mcand << 1;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_x     <= n_x;
        r_y     <= n_y;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_gcd   <= n_gcd;
        r_rem   <= n_rem;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_err   <= n_err;
    end

    assign o_stat.idle   = (r_state == S_IDLE);
    assign o_stat.done   = (r_state == S_DONE);
    assign o_result.err  = r_err;
    assign o_result.gcd  = FIELD_W'(r_gcd);
    assign o_result.lcm  = LCM_W'(r_acc);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("start seen while the sequencer is busy");

    a_reduce_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE) |-> (r_x != '0 && r_y != '0))
        else $error("GCD reduction reached a zero operand");

    a_rem_below_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_gcd))
        else $error("division remainder not below the divisor");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_err) |-> (r_gcd != '0 && r_acc != '0))
        else $error("finished without error but with a zero result");

endmodule

`default_nettype wire

>>> rtl/gcd_lcm_unit_top.sv
// Top level of the GCD/LCM unit: stream ports, sequencer and result register.
//
//  Channel   Dir  Fields
//  s_axis    in   tdata[15:0] operand_a, tdata[31:16] operand_b
//  m_axis    out  tdata[15:0] gcd_value, tdata[47:16] lcm_value, tuser zero_error
//
// An item occupies the unit for binary GCD steps, then W restoring-division steps, then one
// shift-add step per quotient bit, all through one shared adder. A zero operand skips these
// steps and goes straight to the finished state.
// Reset is synchronous and active low; it clears the sequencer state and the output valid.
// The result sits in an output register, so the next item is accepted while it waits;
// a finished item waits in the sequencer only while that register is still full.
`default_nettype none

module gcd_lcm_unit_top
    import gcl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // operand_a, operand_b
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,  // gcd_value, lcm_value
    output logic                       o_m_axis_tuser   // zero_error
);

    t_seq_stat w_stat;
    t_result   w_result;
    logic      w_start;
    logic      w_take;
    logic      r_out_valid;
    t_result   r_out;

    assign o_s_axis_tready = w_stat.idle;
    assign w_start         = i_s_axis_tvalid & w_stat.idle;
    assign w_take          = w_stat.done & (~r_out_valid | i_m_axis_tready);

    gcl_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_operand_a (i_s_axis_tdata[FIELD_W-1:0]),
        .i_operand_b (i_s_axis_tdata[IN_DATA_W-1:FIELD_W]),
        .i_take      (w_take),
        .o_stat      (w_stat),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.lcm, r_out.gcd};
    assign o_m_axis_tuser  = r_out.err;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the GCD/LCM unit: directed table, then random operand pairs.
module testbench
    import gcl_pkg::*;
();

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        bit                 typed;
        t_result            want;
    } t_vector;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // operand_a, operand_b
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // gcd_value, lcm_value
    logic                  o_m_axis_tuser;   // zero_error

    t_result pending_results[$];
    t_vector directed_rows[$];
    int      mismatch_count = 0;
    int      accepted_items;
    int      cycle_count = 0;

    gcd_lcm_unit_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Euclid on the masked operands; lcm is a / gcd * b with saturation to 32 bits.
    function automatic t_result gcd_lcm_of(input logic [FIELD_W-1:0] a_in,
                                           input logic [FIELD_W-1:0] b_in);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] g;
        logic [63:0] r;
        logic [63:0] t;
        t_result     res;
        mask = (OPERAND_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << OPERAND_WIDTH) - 64'd1);
        a    = {48'd0, a_in} & mask;
        b    = {48'd0, b_in} & mask;
        res  = '0;
        if (a == 64'd0 || b == 64'd0) begin
            res.err = 1'b1;
            return res;
        end
        g = a;
        r = b;
        while (r != 64'd0) begin
            t = g % r;
            g = r;
            r = t;
        end
        t = (a / g) * b;
        if (t > 64'hFFFF_FFFF)
            t = 64'hFFFF_FFFF;
        res.gcd = g[FIELD_W-1:0];
        res.lcm = t[LCM_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, a few long ones; zero means back-to-back.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                           input bit typed, input logic err, input logic [LCM_W-1:0] lcm,
                           input logic [FIELD_W-1:0] gcd);
        t_vector row;
        row.a        = a;
        row.b        = b;
        // Hand-typed values assume the full 16-bit operand width.
        row.typed    = typed && (OP_W == FIELD_W);
        row.want.err = err;
        row.want.lcm = lcm;
        row.want.gcd = gcd;
        directed_rows.push_back(row);
    endtask

    // Offer one operand pair and hold it until the transfer happens.
    task automatic send_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                             input t_result want, input int gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, a};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        pending_results.push_back(want);
        accepted_items++;
    endtask

    initial begin
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        int                 pick;
        int                 factor;
        int                 burst_left;
        int                 gap;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        accepted_items  = 0;
        burst_left      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(16'h0000, 16'h0000, 1, 1'b1, 32'd0,        16'h0000);
        add_row(16'h0000, 16'h1234, 1, 1'b1, 32'd0,        16'h0000);
        add_row(16'hABCD, 16'h0000, 1, 1'b1, 32'd0,        16'h0000);
        add_row(16'h0001, 16'h0000, 1, 1'b1, 32'd0,        16'h0000);
        add_row(16'hFFFF, 16'hFFFF, 1, 1'b0, 32'h0000FFFF, 16'hFFFF);
        add_row(16'h0001, 16'h0001, 1, 1'b0, 32'd1,        16'h0001);
        add_row(16'h0001, 16'hFFFF, 1, 1'b0, 32'h0000FFFF, 16'h0001);
        add_row(16'hFFFF, 16'h0001, 1, 1'b0, 32'h0000FFFF, 16'h0001);
        add_row(16'hFFFF, 16'hFFFE, 1, 1'b0, 32'hFFFD0002, 16'h0001);
        add_row(16'hFFFE, 16'hFFFF, 1, 1'b0, 32'hFFFD0002, 16'h0001);
        add_row(16'h8000, 16'h8000, 1, 1'b0, 32'h00008000, 16'h8000);
        add_row(16'h8000, 16'h4000, 1, 1'b0, 32'h00008000, 16'h4000);
        add_row(16'h8000, 16'h0001, 1, 1'b0, 32'h00008000, 16'h0001);
        add_row(16'h0007, 16'h0007, 1, 1'b0, 32'd7,        16'h0007);
        add_row(16'd65521, 16'd65519, 0, 1'b0, 32'd0, 16'd0);
        add_row(16'd12,    16'd18,    0, 1'b0, 32'd0, 16'd0);
        add_row(16'd48,    16'd36,    0, 1'b0, 32'd0, 16'd0);
        add_row(16'hAAAA,  16'h5555,  0, 1'b0, 32'd0, 16'd0);
        add_row(16'h5555,  16'hAAAA,  0, 1'b0, 32'd0, 16'd0);
        add_row(16'h0002,  16'hFFFE,  0, 1'b0, 32'd0, 16'd0);
        add_row(16'hFFF0,  16'h0F0F,  0, 1'b0, 32'd0, 16'd0);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].typed ? directed_rows[i].want
                                             : gcd_lcm_of(directed_rows[i].a,
                                                          directed_rows[i].b),
                      idle_gap());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // One operand zero, the other anything.
                a = 16'($urandom_range(0, 65535));
                b = 16'($urandom_range(0, 65535));
                if (pick < 4)
                    a = '0;
                else
                    b = '0;
            end else if (pick < 48) begin
                a = 16'($urandom_range(0, 65535));
                b = 16'($urandom_range(0, 65535));
            end else if (pick < 73) begin
                // Shared factor, so the gcd is a multiple of it.
                factor = $urandom_range(1, 255);
                a      = 16'(factor * $urandom_range(1, 65535 / factor));
                b      = 16'(factor * $urandom_range(1, 65535 / factor));
            end else if (pick < 85) begin
                a = 16'($urandom_range(1, 65535) << $urandom_range(0, 15));
                b = 16'($urandom_range(1, 65535) << $urandom_range(0, 15));
            end else if (pick < 95) begin
                a = 16'($urandom_range(1, 20));
                b = 16'($urandom_range(1, 20));
            end else begin
                a = $urandom_range(0, 1) ? 16'hFFFF : 16'h8000;
                b = $urandom_range(0, 1) ? a : 16'($urandom_range(0, 65535));
            end
            if (burst_left == 0 && $urandom_range(0, 99) < 3)
                burst_left = $urandom_range(20, 40);
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = idle_gap();
            end
            send_pair(a, b, gcd_lcm_of(a, b), gap);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stalls, runs of full rate, and one long hold-off
    // while the sender keeps offering, so the unit backs up into its input.
    initial begin
        bit held;
        i_m_axis_tready = 1'b0;
        held            = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held && accepted_items >= 200) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 1) == 0) begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 50)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat (idle_gap() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.gcd = o_m_axis_tdata[FIELD_W-1:0];
            got.lcm = o_m_axis_tdata[FIELD_W +: LCM_W];
            got.err = o_m_axis_tuser;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: gcd %h lcm %h zero_error %b",
                             got.gcd, got.lcm, got.err);
            end else begin
                want = pending_results.pop_front();
                if (got.gcd !== want.gcd || got.lcm !== want.lcm || got.err !== want.err) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: expected gcd %h lcm %h zero_error %b, ",
                                  "got gcd %h lcm %h zero_error %b"},
                                 want.gcd, want.lcm, want.err, got.gcd, got.lcm, got.err);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
